// ===== sv/libf_pkg.sv =====
// ----------------------------------------------------------------------------
// libf_pkg: shared types and constants for the label inner boundary filter
// Register indexes, request kinds and configuration widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package libf_pkg;

    // Configuration register widths
    localparam int CFG_WIDTH_BITS  = 13;
    localparam int CFG_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;

    // Configuration reset values
    localparam logic [CFG_WIDTH_BITS-1:0]  IMAGE_WIDTH_RESET  = 13'd256;
    localparam logic [CFG_HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = 16'd256;

    // Configuration register index
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Request kind carried in tuser
    typedef enum logic [0:0] {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_type_t;

endpackage

`default_nettype wire

// ===== sv/label_inner_boundary_filter.sv =====
// ----------------------------------------------------------------------------
// label_inner_boundary_filter: 4-connected inner boundary of a label image
// Clears interior pixels of positive labels, passes outlines and borders.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid / s_tready    s_tdata label_in, s_tuser req_type
//   m_*      out        m_tvalid / m_tready    m_tdata label_out, m_tlast frame_last
//   cfg_*    in         cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// One request per cycle while s_tready is high. A line memory of {pending row,
// row above} words is read ahead through its registered read ports at the
// columns the next request needs (center, right), with forwarding of the write
// made in the same cycle. After reset and in the cycle after each register
// write, s_tready is low while the line memory is read at the new position.
// No clearing pass. A result leaves through an output register and a skid
// stage; s_tready also drops while both hold a result.
// ----------------------------------------------------------------------------
`default_nettype none

module label_inner_boundary_filter #(
    parameter int MAX_WIDTH  = 4096,
    parameter int LABEL_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input requests
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((LABEL_BITS+7)/8)*8-1:0]      s_tdata,   // [LABEL_BITS-1:0] label_in
    input  logic [0:0]                           s_tuser,   // [0] req_type
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((LABEL_BITS+7)/8)*8-1:0]      m_tdata,   // [LABEL_BITS-1:0] label_out
    output logic                                 m_tlast,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  libf_pkg::cfg_index_t                 cfg_index,
    input  logic [libf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import libf_pkg::*;

    localparam int TDW  = ((LABEL_BITS + 7) / 8) * 8;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (EW > CFG_WIDTH_BITS) ? EW : CFG_WIDTH_BITS;
    localparam int L    = LABEL_BITS;
    localparam int RW   = CFG_HEIGHT_BITS;

    // Configuration and position state
    logic [CFG_WIDTH_BITS-1:0]  width_cfg_reg;
    logic [CFG_HEIGHT_BITS-1:0] height_cfg_reg;
    logic                       stale_reg;
    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    logic [EW-1:0]              pend_reg, pend_next;
    logic [L-1:0]               left_reg, left_next;

    // Line memory and forwarding
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic [2*L-1:0]   wr_data;
    logic [CW-1:0]    rd_addr_a, rd_addr_b;
    logic [2*L-1:0]   rd_data_a, rd_data_b;
    logic             fwd_a_reg, fwd_b_reg;
    logic [2*L-1:0]   fwd_data_reg;
    logic [2*L-1:0]   word_a, word_b;

    // Datapath
    logic [EW-1:0]    eff_w;
    logic [RW-1:0]    eff_h;
    logic [CMPW-1:0]  width_ext;
    logic             s_acc, is_drain, flushing;
    logic [CW-1:0]    c0;
    logic [RW-1:0]    r0;
    logic [L-1:0]     down, center, up, right;
    logic             interior, inside_region;
    logic             res_valid, res_last;
    logic [L-1:0]     res_label;
    logic             flush_n;
    logic [CW-1:0]    c0_n, drain_col_n;
    logic             skid_full;
    logic [L:0]       out_word;

    // Effective frame size
    always_comb
    begin
        width_ext = CMPW'(width_cfg_reg);
        if (width_cfg_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (width_ext > CMPW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(width_ext);
        end
        eff_h = (height_cfg_reg == '0) ? RW'(1) : height_cfg_reg;
    end

    // Apply forwarding to the registered memory words
    assign word_a = fwd_a_reg ? fwd_data_reg : rd_data_a;
    assign word_b = fwd_b_reg ? fwd_data_reg : rd_data_b;
    assign center = word_a[2*L-1:L];
    assign up     = word_a[L-1:0];
    assign right  = word_b[2*L-1:L];
    assign down   = s_tdata[L-1:0];

    assign s_acc    = s_tvalid && s_tready;
    assign is_drain = (s_tuser == REQ_DRAIN);
    assign flushing = (row_reg >= eff_h) && (pend_reg != '0);
    assign r0       = (row_reg >= eff_h) ? '0 : row_reg;
    assign c0       = ((row_reg >= eff_h) || (EW'(col_reg) >= eff_w)) ? '0 : col_reg;
    assign interior = (r0 >= RW'(2)) && (c0 != '0) && ((EW'(c0) + 1'b1) < eff_w);
    assign inside_region = (center != '0) && !center[L-1] && (up == center) &&
                           (down == center) && (left_reg == center) &&
                           (right == center);

    // Decide the pixel or drain request and advance the position
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        left_next = left_reg;
        wr_en     = 1'b0;
        wr_addr   = c0;
        wr_data   = {down, center};
        res_valid = 1'b0;
        res_last  = 1'b0;
        res_label = center;
        if (s_acc)
        begin
            if (is_drain)
            begin
                if (flushing)
                begin
                    pend_next = pend_reg - 1'b1;
                    res_valid = 1'b1;
                    res_last  = (pend_reg == EW'(1));
                    if (pend_reg == EW'(1))
                    begin
                        row_next = '0;
                        col_next = '0;
                    end
                end
            end
            else if (!flushing)
            begin
                res_valid = (r0 != '0);
                if (interior && inside_region)
                begin
                    res_label = '0;
                end
                left_next = center;
                wr_en     = 1'b1;
                if ((EW'(c0) + 1'b1) >= eff_w)
                begin
                    col_next = '0;
                    row_next = r0 + 1'b1;
                    if ((r0 + 1'b1) >= eff_h)
                    begin
                        row_next  = eff_h;
                        pend_next = eff_w;
                    end
                end
                else
                begin
                    col_next = c0 + 1'b1;
                    row_next = r0;
                end
            end
        end
    end

    // Read ahead at the columns the next request needs
    always_comb
    begin
        flush_n     = (row_next >= eff_h) && (pend_next != '0);
        drain_col_n = (pend_next <= eff_w) ? CW'(eff_w - pend_next) : '0;
        c0_n        = ((row_next >= eff_h) || (EW'(col_next) >= eff_w)) ? '0 : col_next;
        rd_addr_a   = flush_n ? drain_col_n : c0_n;
        rd_addr_b   = (c0_n == CW'(MAX_WIDTH - 1)) ? '0 : c0_n + 1'b1;
    end

    libf_ram #(
        .WIDTH (2 * L),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // Hold control state, configuration and forwarding flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= IMAGE_WIDTH_RESET;
            height_cfg_reg <= IMAGE_HEIGHT_RESET;
            stale_reg      <= 1'b1;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_reg       <= '0;
            left_reg       <= '0;
            fwd_a_reg      <= 1'b0;
            fwd_b_reg      <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            left_reg  <= left_next;
            fwd_a_reg <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg <= wr_en && (wr_addr == rd_addr_b);
            stale_reg <= cfg_valid;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[CFG_WIDTH_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[CFG_HEIGHT_BITS-1:0];
                    default:          width_cfg_reg  <= width_cfg_reg;
                endcase
            end
        end
    end

    // Hold the forwarded write word
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

    libf_skid #(
        .DW (L + 1)
    ) u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   ({res_last, res_label}),
        .full      (skid_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign s_tready  = !skid_full && !stale_reg;
    assign cfg_ready = 1'b1;
    assign m_tdata   = TDW'(out_word[L-1:0]);
    assign m_tlast   = out_word[L];

    // A register write blocks input for the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !s_tready)
        else $error("input accepted right after a register write");

    // A drain request during flush takes exactly one pending pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_DRAIN) && flushing)
        |=> (pend_reg == $past(pend_reg) - 1'b1))
        else $error("pending count did not step on drain");

    // A full skid stage implies a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> m_tvalid)
        else $error("skid stage full with empty output register");

    // A new result only follows an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without a request");

endmodule

`default_nettype wire

// ===== sv/libf_ram.sv =====
// ----------------------------------------------------------------------------
// libf_ram: generic synchronous RAM
// One write port and two read ports, read data registered (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module libf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== sv/libf_skid.sv =====
// ----------------------------------------------------------------------------
// libf_skid: output register with skid stage
// Holds up to two results so the input side never waits on tready directly.
// ----------------------------------------------------------------------------
`default_nettype none

module libf_skid #(
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [DW-1:0] out_data_reg, out_data_next;
    logic [DW-1:0] skid_data_reg, skid_data_next;

    // Refill the output register from the skid stage first, then from the new request
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = in_valid;
                skid_data_next  = in_data;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for label_inner_boundary_filter
// Streams label frames in raster order with drain ticks and stray requests,
// predicts each outline pixel and the frame end mark, and compares every
// result in order. Both stream sides idle at random and the result side holds
// off once for a long stretch so that the filter stalls its input.
// ----------------------------------------------------------------------------

module tb;

    import libf_pkg::*;

    localparam int MAX_W        = 4096;
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1250;
    localparam int WIDE_PIXELS  = 200;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        req_type_t   kind;
        logic [15:0] label;
    } pixel_req_t;

    typedef struct packed {
        logic [15:0] label;
        logic        last;
    } boundary_px_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [15:0]                    m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    cfg_index_t                     cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0]       cfg_data  = '0;

    // request source and expected outline pixels
    pixel_req_t   pixel_reqs [$];
    boundary_px_t expected_px [$];
    pixel_req_t   next_req;
    boundary_px_t due_px;
    bit           req_taken;

    // geometry and window state of the filter as predicted
    logic [12:0]  geo_width  = IMAGE_WIDTH_RESET;
    logic [15:0]  geo_height = IMAGE_HEIGHT_RESET;
    logic [15:0]  above_row [0:MAX_W-1];
    logic [15:0]  pend_row  [0:MAX_W-1];
    logic [15:0]  left_lbl  = '0;
    int unsigned  col_pos    = 0;
    int unsigned  row_pos    = 0;
    int unsigned  drain_left = 0;

    // idling control
    int  gap_odds    = 3;
    int  stall_odds  = 3;
    int  src_gap     = 0;
    int  sink_gap    = 0;
    int  hold_left   = 0;
    bit  calm        = 1'b0;
    bit  squeeze_req = 1'b0;
    bit  squeeze_done = 1'b0;

    // bookkeeping
    int  mismatches   = 0;
    int  items_done   = 0;
    int  results_seen = 0;
    int  frame_ends   = 0;
    int  reqs_taken   = 0;
    int  input_stalls = 0;
    int  cycles       = 0;

    label_inner_boundary_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [15:0] label_in
        .s_tuser   (s_tuser),     // [0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [15:0] label_out
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Advance the predicted filter by one accepted request
    task automatic predict_boundary(input req_type_t kind, input logic [15:0] lbl);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned col;
        logic [15:0] center;
        logic [15:0] res;
        bit          flushing;
        w = (geo_width == 0) ? 1 : ((geo_width > MAX_W) ? MAX_W : geo_width);
        h = (geo_height == 0) ? 1 : geo_height;
        flushing = (row_pos >= h) && (drain_left > 0);
        if (kind == REQ_DRAIN) begin
            // emit one pixel of the last row, clamped when the row shrank
            if (flushing) begin
                col = (drain_left <= w) ? (w - drain_left) : 0;
                drain_left--;
                expected_px.push_back('{label: pend_row[col], last: (drain_left == 0)});
                if (drain_left == 0) begin
                    row_pos = 0;
                    col_pos = 0;
                end
            end
        end
        else if (!flushing) begin
            if (row_pos >= h) begin
                row_pos = 0;
                col_pos = 0;
            end
            if (col_pos >= w)
                col_pos = 0;
            c = col_pos;
            center = pend_row[c];
            // decide the pending pixel above the incoming one
            if (row_pos >= 1) begin
                res = center;
                if (row_pos >= 2 && c >= 1 && c + 1 < w) begin
                    if (center != 0 && !center[15] && above_row[c] == center &&
                        lbl == center && left_lbl == center && pend_row[c+1] == center)
                        res = '0;
                end
                expected_px.push_back('{label: res, last: 1'b0});
            end
            left_lbl     = center;
            above_row[c] = center;
            pend_row[c]  = lbl;
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos    = h;
                    drain_left = w;
                end
            end
            else begin
                col_pos = c + 1;
            end
        end
    endtask

    task automatic queue_req(input req_type_t kind, input logic [15:0] lbl);
        pixel_reqs.push_back('{kind: kind, label: lbl});
    endtask

    function automatic logic [15:0] pick_label();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'h7FFF;
            2:       v = 16'h8000;
            3:       v = 16'hFFFF;
            4, 5:    v = 16'($urandom_range(1, 6));
            default: v = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return v;
    endfunction

    // Queue npix pixels of a w x h frame made of labelled blocks, with stray
    // drains while receiving and stray pixels while flushing
    task automatic queue_frame(input int w, input int h, input int npix,
                               input int bw, input int bh);
        logic [15:0] palette [4];
        logic [15:0] lbl;
        int          r;
        int          c;
        int          k;
        for (k = 0; k < 4; k++)
            palette[k] = pick_label();
        for (k = 0; k < npix; k++) begin
            r = k / w;
            c = k % w;
            if ($urandom_range(0, 15) == 0)
                queue_req(REQ_DRAIN, 16'($urandom_range(0, 16'hFFFF)));
            if ($urandom_range(0, 11) == 0)
                lbl = 16'($urandom_range(0, 16'hFFFF));
            else
                lbl = palette[(r / bh + 2 * (c / bw)) % 4];
            queue_req(REQ_PIXEL, lbl);
        end
        if (npix == w * h) begin
            for (k = 0; k < w; k++) begin
                if ($urandom_range(0, 15) == 0)
                    queue_req(REQ_PIXEL, 16'($urandom_range(0, 16'hFFFF)));
                queue_req(REQ_DRAIN, 16'($urandom_range(0, 16'hFFFF)));
            end
            items_done += w;
        end
        items_done += npix;
    endtask

    // Hold until every request is taken and every result is back, then let
    // the pipeline run empty
    task automatic wait_for_idle();
        @(posedge clk);
        while (pixel_reqs.size() != 0 || s_tvalid || expected_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH)
            geo_width = val[12:0];
        else
            geo_height = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drive requests at the falling edge, with random gaps between them
    always @(negedge clk) begin
        if (rst_n) begin
            if (src_gap > 0)
                src_gap--;
            else if (!calm && gap_odds != 0 && $urandom_range(0, 15) < gap_odds)
                src_gap = $urandom_range(1, 10);
            if (!s_tvalid || req_taken) begin
                if (src_gap == 0 && pixel_reqs.size() != 0) begin
                    next_req = pixel_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.kind;
                    s_tdata  <= next_req.label;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Drive result ready: random stalls plus one long hold-off
    always @(negedge clk) begin
        if (squeeze_req && !squeeze_done) begin
            hold_left    = HOLD_CYCLES;
            squeeze_done = 1'b1;
        end
        if (hold_left > 0)
            hold_left--;
        else if (sink_gap > 0)
            sink_gap--;
        else if (!calm && stall_odds != 0 && $urandom_range(0, 15) < stall_odds)
            sink_gap = $urandom_range(1, 10);
        m_tready <= (hold_left == 0 && sink_gap == 0);
    end

    // Check results and predict from accepted requests at the rising edge
    always @(posedge clk) begin
        req_taken = s_tvalid && s_tready;
        if (rst_n) begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tlast)
                    frame_ends++;
                if (expected_px.size() == 0) begin
                    $display("%0t: result with none expected: label %0d, last %0b",
                             $time, $signed(m_tdata), m_tlast);
                    mismatches++;
                end
                else begin
                    due_px = expected_px.pop_front();
                    if (m_tdata !== due_px.label) begin
                        $display("%0t: label mismatch: expected %0d, got %0d",
                                 $time, $signed(due_px.label), $signed(m_tdata));
                        mismatches++;
                    end
                    if (m_tlast !== due_px.last) begin
                        $display("%0t: frame end mismatch: expected %0b, got %0b",
                                 $time, due_px.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (req_taken) begin
                reqs_taken++;
                predict_boundary(req_type_t'(s_tuser), s_tdata);
            end
        end
    end

    // Bound the run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int fw;
        int fh;
        int k;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single pixel frame with zero registers, stray pixel and drains
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        queue_req(REQ_PIXEL, 16'd7);
        queue_req(REQ_PIXEL, 16'hFFFF);
        queue_req(REQ_DRAIN, 16'h1234);
        queue_req(REQ_DRAIN, 16'h0000);
        wait_for_idle();

        // 3x3 of the largest positive label: the center clears
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        for (k = 0; k < 9; k++) begin
            if (k == 4)
                queue_req(REQ_DRAIN, 16'hA5A5);
            queue_req(REQ_PIXEL, 16'h7FFF);
        end
        for (k = 0; k < 3; k++)
            queue_req(REQ_DRAIN, 16'h0000);
        wait_for_idle();

        // one column, tallest frame, cut short by a smaller height
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        queue_req(REQ_PIXEL, 16'h8000);
        queue_req(REQ_PIXEL, 16'h0000);
        queue_req(REQ_PIXEL, 16'h0001);
        queue_req(REQ_PIXEL, 16'hFFFF);
        wait_for_idle();
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        queue_req(REQ_PIXEL, 16'd5);
        queue_req(REQ_PIXEL, 16'd6);
        queue_req(REQ_DRAIN, 16'h0000);
        wait_for_idle();

        // narrow the row during the flush: drain column clamps to the start
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        queue_req(REQ_PIXEL, 16'd11);
        queue_req(REQ_PIXEL, 16'd12);
        queue_req(REQ_PIXEL, 16'd13);
        wait_for_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        for (k = 0; k < 3; k++)
            queue_req(REQ_DRAIN, 16'h0000);
        wait_for_idle();

        // widest row: width register saturates at the line buffer depth,
        // hold the first row open part way
        gap_odds   = 2;
        stall_odds = 2;
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        queue_frame(MAX_W, 3, WIDE_PIXELS, 64, 4);
        wait_for_idle();

        // random frames, the first one under a long result hold-off
        items_done = 0;
        fw = 16;
        fh = 8;
        write_reg(CFG_IMAGE_WIDTH, 16'(fw));
        write_reg(CFG_IMAGE_HEIGHT, 16'(fh));
        squeeze_req = 1'b1;
        queue_frame(fw, fh, fw * fh, 2, 2);
        while (items_done < RANDOM_ITEMS) begin
            calm = items_done > RANDOM_ITEMS - 250;
            gap_odds   = $urandom_range(0, 4);
            stall_odds = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0) begin
                fw = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
                fh = $urandom_range(1, 8);
                wait_for_idle();
                write_reg(CFG_IMAGE_WIDTH, 16'(fw));
                write_reg(CFG_IMAGE_HEIGHT, 16'(fh));
            end
            // stop a frame part way and restart it with a smaller height
            if (fh >= 2 && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, fh - 1);
                queue_frame(fw, fh, k * fw + $urandom_range(0, fw - 1),
                            $urandom_range(1, 4), $urandom_range(1, 4));
                wait_for_idle();
                fh = $urandom_range(1, k);
                write_reg(CFG_IMAGE_HEIGHT, 16'(fh));
            end
            queue_frame(fw, fh, fw * fh, $urandom_range(1, 4), $urandom_range(1, 4));
            while (pixel_reqs.size() > 64)
                @(posedge clk);
        end
        wait_for_idle();

        $display("Checked %0d outline pixels and %0d frame ends from %0d requests,",
                 results_seen, frame_ends, reqs_taken);
        $display("widths 0 to 40 plus an open saturated row, heights up to 65535,");
        $display("input stalled %0d cycles.", input_stalls);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/libf_pkg.sv
sv/libf_ram.sv
sv/libf_skid.sv
sv/label_inner_boundary_filter.sv
tb/sv/tb.sv
